// File: src/rgb_image_fitness_assert.svh
// Assertion macros for the rgb_image_fitness checker.
// Standalone; the including scope must provide clock and reset.
`ifndef RGB_IMAGE_FITNESS_ASSERT_SVH
`define RGB_IMAGE_FITNESS_ASSERT_SVH

// same-cycle implication, off during reset
`define RGBFIT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RGBFIT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, also checked across reset
`define RGBFIT_ASSERT_NEXT_ANY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rgbfit_pkg.sv
// Shared types and constants for the RGB image fitness block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgbfit_pkg;

   localparam int PIX_W   = 8;
   localparam int SQ_W    = 18;  // 3 * 255^2 fits in 18 bits
   localparam int RAD_W   = 34;  // radicand: squared sum << 16
   localparam int ROOT_W  = 35;
   localparam int DIST_W  = 17;  // per-pixel distance, Q9.8
   localparam int SUM_W   = 37;  // running total, Q29.8
   localparam int SEEN_W  = 20;
   localparam int PC_W    = 21;
   localparam int FIT_W   = 17;  // Q1.16 fitness
   localparam int REM_W   = SUM_W + 1;
   localparam int STEP_W  = 5;

   localparam int ROOT_STEPS = ROOT_W / 2 + 1;  // 18 root digits
   localparam int DIV_STEPS  = FIT_W;           // 17 quotient bits

   localparam logic [PC_W-1:0]   MAX_PIXELS    = 21'd1048576;
   localparam logic [DIST_W-1:0] PIX_MAX_DIST  = 17'd113068;  // isqrt(3*255^2 << 16)
   localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = {1'b1, {(ROOT_W-1){1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_ACCUM,
      ST_MULT,
      ST_DIV_INIT,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;       // capture item, start root
      logic root_step;
      logic accum;
      logic mult;
      logic div_init;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_pixel; // this item completes the image
      logic out_free;   // result register can take a new value
   } status_type;

endpackage

`default_nettype wire

// File: src/rgb_image_fitness.sv
// Top level of the RGB image fitness block: sequencer plus datapath.
// Depends on rgbfit_pkg, rgbfit_ctrl, rgbfit_dp.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   req     | in        | req_valid / req_stall | candidate and goal RGB pixel
//   rsp     | out       | rsp_valid / rsp_stall | total_distance, fitness
//   csr     | in        | csr_write             | pixel_count (21 bits)
//
// An ordinary pixel is taken with its channel differences squared, then
// runs 18 steps of the restoring square root and one add.
// The pixel that ends an image goes on with a constant multiply for the
// maximum, divider setup, 17 quotient steps and the result load.
// req_stall is low only in the idle state, so a new pixel is taken only
// after the last one is through.
// Reset (synchronous) clears the total, pixel counter and result valid,
// and sets pixel_count to 1048576.
// A result waiting under rsp_stall does not hold up the next pixels; only
// the next image end waits for the result register to free up.
`timescale 1ns / 1ps
`default_nettype none

module rgb_image_fitness import rgbfit_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   // pixel pairs in
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [PIX_W-1:0]  req_cand_red,
   input  wire logic [PIX_W-1:0]  req_cand_green,
   input  wire logic [PIX_W-1:0]  req_cand_blue,
   input  wire logic [PIX_W-1:0]  req_goal_red,
   input  wire logic [PIX_W-1:0]  req_goal_green,
   input  wire logic [PIX_W-1:0]  req_goal_blue,
   // per-image result out
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [SUM_W-1:0]       rsp_total_distance,
   output logic [FIT_W-1:0]       rsp_fitness,
   // pixel count register
   input  wire logic              csr_write,
   input  wire logic [PC_W-1:0]   csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rgbfit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rgbfit_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cand_red       (req_cand_red),
      .req_cand_green     (req_cand_green),
      .req_cand_blue      (req_cand_blue),
      .req_goal_red       (req_goal_red),
      .req_goal_green     (req_goal_green),
      .req_goal_blue      (req_goal_blue),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_distance (rsp_total_distance),
      .rsp_fitness        (rsp_fitness)
   );

endmodule

`default_nettype wire

// File: src/rgbfit_ctrl.sv
// Sequencer for the RGB image fitness block: steps the root and divide loops.
// Depends on rgbfit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbfit_ctrl import rgbfit_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = STEP_W'(ROOT_STEPS - 1);
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            cnt_in        = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last_pixel ? ST_MULT : ST_IDLE;
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = STEP_W'(DIV_STEPS - 1);
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: src/rgbfit_dp.sv
// Datapath: channel squares, bit-serial square root, accumulator,
// fitness divider and result register. Depends on rgbfit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgbfit_dp import rgbfit_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [PIX_W-1:0]  req_cand_red,
   input  wire logic [PIX_W-1:0]  req_cand_green,
   input  wire logic [PIX_W-1:0]  req_cand_blue,
   input  wire logic [PIX_W-1:0]  req_goal_red,
   input  wire logic [PIX_W-1:0]  req_goal_green,
   input  wire logic [PIX_W-1:0]  req_goal_blue,
   input  wire logic              csr_write,
   input  wire logic [PC_W-1:0]   csr_wdata,
   input  wire cmd_type           cmd,
   output status_type             status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [SUM_W-1:0]       rsp_total_distance,
   output logic [FIT_W-1:0]       rsp_fitness
);

   function automatic logic [2*PIX_W-1:0] chan_sq(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [PIX_W-1:0] d;
      d = (a > b) ? a - b : b - a;
      return {{PIX_W{1'b0}}, d} * {{PIX_W{1'b0}}, d};
   endfunction

   // control/state registers
   logic [PC_W-1:0]   pixel_count_ff;
   logic [SUM_W-1:0]  dsum_ff, dsum_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [RAD_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [ROOT_W-1:0] bit_ff, bit_in;
   logic [SUM_W-1:0]  tot_ff, tot_in;
   logic [SUM_W-1:0]  maxv_ff, maxv_in;
   logic [REM_W-1:0]  drem_ff, drem_in;
   logic [FIT_W-1:0]  quot_ff, quot_in;
   logic              over_ff, over_in;
   logic [SUM_W-1:0]  rsp_tot_ff, rsp_tot_in;
   logic [FIT_W-1:0]  rsp_fit_ff, rsp_fit_in;

   logic [SQ_W-1:0]        sq;
   logic [ROOT_W:0]        trial;
   logic                   root_ge;
   logic [DIST_W-1:0]      pix_dist;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [PC_W-1:0]        count;
   logic [PC_W-1:0]        pc_eff;
   logic [PC_W+DIST_W-1:0] prod;
   logic                   div_ge;
   logic [REM_W-1:0]       div_sub;

   always_comb begin
      sq = {2'b0, chan_sq(req_cand_red,   req_goal_red)}
         + {2'b0, chan_sq(req_cand_green, req_goal_green)}
         + {2'b0, chan_sq(req_cand_blue,  req_goal_blue)};

      trial    = {1'b0, root_ff} + {1'b0, bit_ff};
      root_ge  = {2'b0, rem_ff} >= trial;
      pix_dist = root_ff[DIST_W-1:0];

      sum_wide = {1'b0, dsum_ff} + {{(SUM_W+1-DIST_W){1'b0}}, pix_dist};
      sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      count    = {1'b0, seen_ff} + 1'b1;

      // zero acts as one, anything above the limit as the limit
      if (pixel_count_ff == '0)            pc_eff = PC_W'(1);
      else if (pixel_count_ff > MAX_PIXELS) pc_eff = MAX_PIXELS;
      else                                 pc_eff = pixel_count_ff;

      prod = {{DIST_W{1'b0}}, pc_eff} * {{PC_W{1'b0}}, PIX_MAX_DIST};

      div_ge  = drem_ff >= {1'b0, maxv_ff};
      div_sub = div_ge ? drem_ff - {1'b0, maxv_ff} : drem_ff;

      status.last_pixel = count >= pc_eff;
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // next values
   always_comb begin
      rem_in     = rem_ff;
      root_in    = root_ff;
      bit_in     = bit_ff;
      dsum_in    = dsum_ff;
      seen_in    = seen_ff;
      tot_in     = tot_ff;
      maxv_in    = maxv_ff;
      drem_in    = drem_ff;
      quot_in    = quot_ff;
      over_in    = over_ff;
      rsp_tot_in = rsp_tot_ff;
      rsp_fit_in = rsp_fit_ff;

      if (cmd.load) begin
         rem_in  = {sq, 16'b0};
         root_in = '0;
         bit_in  = ROOT_BIT_INIT;
      end
      if (cmd.root_step) begin
         if (root_ge) begin
            rem_in  = rem_ff - trial[RAD_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
      if (cmd.accum) begin
         if (status.last_pixel) begin
            tot_in  = sum_sat;
            dsum_in = '0;
            seen_in = '0;
         end else begin
            dsum_in = sum_sat;
            seen_in = count[SEEN_W-1:0];
         end
      end
      if (cmd.mult) maxv_in = prod[SUM_W-1:0];
      if (cmd.div_init) begin
         over_in = tot_ff > maxv_ff;
         drem_in = {1'b0, maxv_ff - tot_ff};
         quot_in = '0;
      end
      if (cmd.div_step) begin
         drem_in = {div_sub[REM_W-2:0], 1'b0};
         quot_in = {quot_ff[FIT_W-2:0], div_ge};
      end
      if (cmd.out_load) begin
         rsp_tot_in = tot_ff;
         rsp_fit_in = over_ff ? '0 : quot_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)                rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= MAX_PIXELS;
         dsum_ff        <= '0;
         seen_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) pixel_count_ff <= csr_wdata;
         dsum_ff      <= dsum_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      root_ff    <= root_in;
      bit_ff     <= bit_in;
      tot_ff     <= tot_in;
      maxv_ff    <= maxv_in;
      drem_ff    <= drem_in;
      quot_ff    <= quot_in;
      over_ff    <= over_in;
      rsp_tot_ff <= rsp_tot_in;
      rsp_fit_ff <= rsp_fit_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_distance = rsp_tot_ff;
   assign rsp_fitness        = rsp_fit_ff;

endmodule

`default_nettype wire

// File: src/rgbfit_checker.sv
// Port-level checks for rgb_image_fitness, bound to the top level.
// Depends on rgbfit_pkg and rgb_image_fitness_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_image_fitness_assert.svh"

module rgbfit_checker import rgbfit_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire logic [SUM_W-1:0] rsp_total_distance,
   input wire logic [FIT_W-1:0] rsp_fitness
);

   `RGBFIT_ASSERT_NEXT_ANY(a_reset_clears_rsp, reset, !rsp_valid, "result valid after reset")

   `RGBFIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_total_distance) && $stable(rsp_fitness), "stalled result moved")

   `RGBFIT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second item taken")

   `RGBFIT_ASSERT_IMPL(a_fit_range, rsp_valid, rsp_fitness <= 17'd65536, "fitness above one")

   `RGBFIT_ASSERT_IMPL(a_fit_one_zero_dist, rsp_valid && rsp_fitness == 17'd65536,
      rsp_total_distance == '0, "full fitness with nonzero distance")

endmodule

bind rgb_image_fitness rgbfit_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_total_distance (rsp_total_distance),
   .rsp_fitness        (rsp_fitness)
);

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for rgb_image_fitness: pixel pairs, idle and stall patterns
// and pixel_count changes, checked against a predictor kept inside the bench.
// Depends on rgbfit_pkg and rgb_image_fitness.
`timescale 1ns / 1ps

module tb_top;
   import rgbfit_pkg::*;

   // one input item: candidate pixel and goal pixel at the same position
   typedef struct packed {
      logic [PIX_W-1:0] cand_red;
      logic [PIX_W-1:0] cand_green;
      logic [PIX_W-1:0] cand_blue;
      logic [PIX_W-1:0] goal_red;
      logic [PIX_W-1:0] goal_green;
      logic [PIX_W-1:0] goal_blue;
   } pixel_pair_type;

   // one per-image result
   typedef struct packed {
      logic [SUM_W-1:0] total_distance;
      logic [FIT_W-1:0] fitness;
   } image_result_type;

   localparam longint unsigned SUM_LIMIT   = (64'd1 << SUM_W) - 1;
   localparam logic [PC_W-1:0] PC_ALL_ONES = '1;  // above MAX_PIXELS, clamps
   localparam int              SETTLE_CYC  = 64;  // settle wait after a drain, longer than the worst pixel
   localparam int              RANDOM_ITEMS = 400;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   pixel_pair_type    req_pair  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b1;
   logic [SUM_W-1:0]  rsp_total_distance;
   logic [FIT_W-1:0]  rsp_fitness;
   logic              csr_write = 1'b0;
   logic [PC_W-1:0]   csr_wdata = '0;

   rgb_image_fitness uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cand_red       (req_pair.cand_red),
      .req_cand_green     (req_pair.cand_green),
      .req_cand_blue      (req_pair.cand_blue),
      .req_goal_red       (req_pair.goal_red),
      .req_goal_green     (req_pair.goal_green),
      .req_goal_blue      (req_pair.goal_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_total_distance (rsp_total_distance),
      .rsp_fitness        (rsp_fitness),
      .csr_write          (csr_write),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   pixel_pair_type   pairs_to_send[$];   // filled by stimulus, drained by driver
   image_result_type images_due[$];      // predicted results, oldest first
   int unsigned   pairs_queued = 0;   // written by stimulus only
   int unsigned   pairs_taken  = 0;   // written by monitor only
   int unsigned   error_count  = 0;
   int unsigned   send_idle_pct = 29;
   int unsigned   recv_idle_pct = 85;
   logic          req_fired = 1'b0;   // item taken at the last rising edge

   // predictor copy of the block state and its register
   logic [SUM_W-1:0]  dist_total;
   logic [SEEN_W-1:0] pixels_in_image;
   logic [PC_W-1:0]   image_size;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic longint unsigned sq_diff(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
      longint unsigned d;
      d = (a > b) ? a - b : b - a;
      return d * d;
   endfunction

   // floor(sqrt(sum of squares) * 256), via integer root of the sum << 16
   function automatic logic [DIST_W-1:0] pixel_distance(input pixel_pair_type p);
      longint unsigned rad, root, bitv;
      rad = (sq_diff(p.cand_red, p.goal_red) + sq_diff(p.cand_green, p.goal_green)
             + sq_diff(p.cand_blue, p.goal_blue)) << 16;
      root = 0;
      bitv = 64'd1 << 34;
      while (bitv > rad)
         bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rad >= root + bitv) begin
            rad  = rad - root - bitv;
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return DIST_W'(root);
   endfunction

   // adds one pixel; returns 1 with the result when it closes the image
   function automatic bit account_pixel(input pixel_pair_type p,
                                        output image_result_type r);
      longint unsigned sum, size, max_total, fit;
      r   = '0;
      sum = dist_total + pixel_distance(p);
      if (sum > SUM_LIMIT)
         sum = SUM_LIMIT;
      // zero acts as one, anything past the limit as the limit
      size = image_size;
      if (size == 0)
         size = 1;
      if (size > MAX_PIXELS)
         size = MAX_PIXELS;
      // a count lowered below the pixels already seen closes on this pixel
      if (pixels_in_image + 1 < size) begin
         dist_total      = SUM_W'(sum);
         pixels_in_image = pixels_in_image + 1'b1;
         return 1'b0;
      end
      max_total = size * PIX_MAX_DIST;
      // a total past the maximum (only after a count change) scores zero
      fit = (sum <= max_total) ? ((max_total - sum) << 16) / max_total : 0;
      r.total_distance = SUM_W'(sum);
      r.fitness        = FIT_W'(fit);
      dist_total       = '0;
      pixels_in_image  = '0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: samples both channels and the register port at the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      image_result_type due;
      if (reset) begin
         dist_total      = '0;
         pixels_in_image = '0;
         image_size      = MAX_PIXELS;
         req_fired       = 1'b0;
      end else begin
         if (csr_write)
            image_size = csr_wdata;
         // results first: an item taken at this edge cannot have produced one
         if (rsp_valid && !rsp_stall) begin
            if (images_due.size() == 0) begin
               $error("result with none pending: total_distance %0d fitness %0d",
                      rsp_total_distance, rsp_fitness);
               error_count++;
            end else begin
               due = images_due.pop_front();
               if (rsp_total_distance !== due.total_distance) begin
                  $error("total_distance: expected %0d, got %0d",
                         due.total_distance, rsp_total_distance);
                  error_count++;
               end
               if (rsp_fitness !== due.fitness) begin
                  $error("fitness: expected %0d, got %0d", due.fitness, rsp_fitness);
                  error_count++;
               end
            end
         end
         req_fired = req_valid && !req_stall;
         if (req_fired) begin
            pairs_taken++;
            if (account_pixel(req_pair, due))
               images_due = {images_due, due};
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: presents items at the falling edge, holds them while stalled
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (pairs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_pair  <= pairs_to_send.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic send_pair(input logic [PIX_W-1:0] cr, input logic [PIX_W-1:0] cg,
                            input logic [PIX_W-1:0] cb, input logic [PIX_W-1:0] gr,
                            input logic [PIX_W-1:0] gg, input logic [PIX_W-1:0] gb);
      pixel_pair_type p;
      p = '{cr, cg, cb, gr, gg, gb};
      pairs_to_send = {pairs_to_send, p};
      pairs_queued++;
   endtask

   // random pair: mostly free content, some identical and some saturated
   function automatic pixel_pair_type random_pair();
      pixel_pair_type p;
      int unsigned kind;
      kind         = $urandom_range(99);
      p.cand_red   = PIX_W'($urandom);
      p.cand_green = PIX_W'($urandom);
      p.cand_blue  = PIX_W'($urandom);
      p.goal_red   = PIX_W'($urandom);
      p.goal_green = PIX_W'($urandom);
      p.goal_blue  = PIX_W'($urandom);
      if (kind < 15) begin
         p.goal_red   = p.cand_red;
         p.goal_green = p.cand_green;
         p.goal_blue  = p.cand_blue;
      end else if (kind < 30) begin
         p.cand_red   = $urandom_range(1) ? 8'hFF : 8'h00;
         p.cand_green = $urandom_range(1) ? 8'hFF : 8'h00;
         p.cand_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
         p.goal_red   = $urandom_range(1) ? 8'hFF : 8'h00;
         p.goal_green = $urandom_range(1) ? 8'hFF : 8'h00;
         p.goal_blue  = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return p;
   endfunction

   // all items taken, all results back, then time for a pixel that
   // closes no image to finish inside the block
   task automatic wait_drained();
      while (pairs_taken != pairs_queued || images_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // register write; only called with the block idle
   task automatic write_size(input logic [PC_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int unsigned random_sent, mode, pick, images, extra, n;
      logic [PC_W-1:0] size;
      random_sent = 0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count is the maximum: three pixels close nothing, then the
      // count drops below what was seen and the next pixel closes the
      // image with a total past the maximum
      send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
      send_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      wait_drained();
      write_size(21'd2);
      send_pair(8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
      wait_drained();

      // zero count acts as one: a result per pixel
      write_size('0);
      send_pair(8'h5A, 8'hA5, 8'h3C, 8'h5A, 8'hA5, 8'h3C);
      send_pair(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
      send_pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55);
      send_pair(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA);
      send_pair(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pair(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00);
      wait_drained();

      // count above the limit clamps; then lowered to one mid-image
      write_size(PC_ALL_ONES);
      send_pair(8'h80, 8'h7F, 8'h01, 8'h7F, 8'h80, 8'hFE);
      send_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pair(8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60);
      wait_drained();
      write_size(21'd1);
      send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
      wait_drained();

      // exact maximum written, then lowered to what was already seen
      write_size(MAX_PIXELS);
      send_pair(8'h12, 8'h34, 8'h56, 8'h65, 8'h43, 8'h21);
      send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      wait_drained();
      write_size(21'd2);
      send_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);

      // random phases; idle pattern moves through three settings
      while (random_sent < RANDOM_ITEMS) begin
         mode = random_sent * 3 / RANDOM_ITEMS;
         wait_drained();
         pick = $urandom_range(99);
         extra = 0;
         if (pick < 10) begin
            size   = '0;
            images = $urandom_range(6, 1);
         end else if (pick < 70) begin
            size   = PC_W'($urandom_range(8, 1));
            images = $urandom_range(4, 1);
         end else if (pick < 95) begin
            size   = PC_W'($urandom_range(40, 9));
            images = $urandom_range(2, 1);
         end else begin
            // huge image: a few pixels only, closed by a later smaller count
            size   = $urandom_range(1) ? MAX_PIXELS : PC_ALL_ONES;
            images = 0;
            extra  = $urandom_range(6, 1);
         end
         if (images != 0 && $urandom_range(3) == 0)
            extra = $urandom_range(3, 1);
         write_size(size);
         send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 85 : 0;
         recv_idle_pct = (mode == 0) ? 85 : (mode == 1) ? 29 : 0;
         n = ((size == 0) ? 1 : size) * images + extra;
         repeat (n) begin
            pairs_to_send = {pairs_to_send, random_pair()};
            pairs_queued++;
         end
         random_sent += n;
      end

      wait_drained();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: rgb_image_fitness.f
+incdir+src
src/rgbfit_pkg.sv
src/rgbfit_ctrl.sv
src/rgbfit_dp.sv
src/rgb_image_fitness.sv
src/rgbfit_checker.sv
bench/tb_top.sv
